### sv/css_pkg.sv
package css_pkg;

   localparam int ELEM_W   = 16;
   localparam int SUM_W    = 43;
   localparam int HALF_W   = 22;
   localparam int PROD_W   = 2 * HALF_W;
   localparam int PNORM_W  = 2 * SUM_W;
   localparam int MAGSQ_W  = 2 * SUM_W - 1;
   localparam int SRCH_W   = 120;
   localparam int Q_W      = 15;
   localparam int FRAC_SH  = 28;
   localparam logic [Q_W-1:0] ONE_Q14 = 15'd16384;

   typedef struct packed {
      logic signed [ELEM_W-1:0] elem_a;
      logic signed [ELEM_W-1:0] elem_b;
      logic                     last_elem;
   } req_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0] similarity;
      logic                     zero_norm;
   } rsp_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] dot;
      logic [SUM_W-1:0]        norm_a;
      logic [SUM_W-1:0]        norm_b;
   } sums_type;

endpackage

### sv/cosine_similarity_stream.sv
// Cosine similarity of two streamed descriptor vectors, one element pair per beat.
// Throughput: the front end takes one beat every cycle unless a last beat waits on a
// full queue; the back end works on one vector pair at a time (load, multiply steps,
// search steps, result), and skips the multiply and search steps when a norm is zero.
// Reset is synchronous and active high; it clears the sums, the queue and the result valid.
module cosine_similarity_stream
   import css_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp
);

   // The front end registers the three products of each beat and then adds
   // them into saturating 43-bit sums. On the last beat the finished sums go
   // into a two-entry queue, so a new vector can stream in while the back end
   // is still busy with the previous one.
   logic     push, q_full, q_empty, pop;
   sums_type push_data, pop_data;

   css_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req),
      .push       (push),
      .push_data  (push_data),
      .queue_full (q_full)
   );

   css_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   // The back end forms norm_a*norm_b and dot^2 with one shared 22 by 22 bit
   // multiplier, then finds the quotient one bit at a time (SRCH_A, SRCH_B) by comparing
   // q^2*norm_a*norm_b against dot^2 scaled by 2^28, built up incrementally.
   css_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (q_empty),
      .queue_data  (pop_data),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp)
   );

   a_zero_norm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.zero_norm |-> rsp.similarity == 16'sd0)
      else $error("zero-norm result with nonzero similarity");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp.similarity <= 16'sd16384) && (rsp.similarity >= -16'sd16384))
      else $error("similarity outside plus or minus one");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !push || pop)
      else $error("queue written while full");

endmodule

### sv/css_front.sv
module css_front
   import css_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  req_type  req_data,
   output logic     push,
   output sums_type push_data,
   input  logic     queue_full
);

   logic                     s1_valid_ff, s1_valid_in;
   logic                     s1_last_ff;
   logic signed [31:0]       s1_ab_ff;
   logic [30:0]              s1_aa_ff, s1_bb_ff;
   logic signed [31:0]       ab_in, aa_w, bb_w;
   logic signed [SUM_W-1:0]  dot_ff, dot_in;
   logic [SUM_W-1:0]         na_ff, na_in, nb_ff, nb_in;
   logic signed [SUM_W:0]    dsum;
   logic [SUM_W:0]           asum, bsum;
   logic                     blocked, advance;

   assign blocked   = s1_valid_ff && s1_last_ff && queue_full;
   assign req_stall = blocked;
   assign advance   = s1_valid_ff && !blocked;

   assign ab_in = 32'(req_data.elem_a) * 32'(req_data.elem_b);
   assign aa_w  = 32'(req_data.elem_a) * 32'(req_data.elem_a);
   assign bb_w  = 32'(req_data.elem_b) * 32'(req_data.elem_b);

   always_comb begin
      s1_valid_in = blocked ? s1_valid_ff : req_valid;
      dsum = {dot_ff[SUM_W-1], dot_ff} + (SUM_W+1)'(s1_ab_ff);
      asum = {1'b0, na_ff} + (SUM_W+1)'(s1_aa_ff);
      bsum = {1'b0, nb_ff} + (SUM_W+1)'(s1_bb_ff);
      if (dsum[SUM_W] != dsum[SUM_W-1]) begin
         dot_in = dsum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         dot_in = dsum[SUM_W-1:0];
      end
      na_in = asum[SUM_W] ? {SUM_W{1'b1}} : asum[SUM_W-1:0];
      nb_in = bsum[SUM_W] ? {SUM_W{1'b1}} : bsum[SUM_W-1:0];
   end

   assign push             = advance && s1_last_ff;
   assign push_data.dot    = dot_in;
   assign push_data.norm_a = na_in;
   assign push_data.norm_b = nb_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         dot_ff      <= '0;
         na_ff       <= '0;
         nb_ff       <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (advance) begin
            if (s1_last_ff) begin
               dot_ff <= '0;
               na_ff  <= '0;
               nb_ff  <= '0;
            end else begin
               dot_ff <= dot_in;
               na_ff  <= na_in;
               nb_ff  <= nb_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!blocked) begin
         s1_last_ff <= req_data.last_elem;
         s1_ab_ff   <= ab_in;
         s1_aa_ff   <= aa_w[30:0];
         s1_bb_ff   <= bb_w[30:0];
      end
   end

endmodule

### sv/css_fifo.sv
module css_fifo
   import css_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  sums_type push_data,
   output logic     full,
   input  logic     pop,
   output sums_type pop_data,
   output logic     empty
);

   sums_type   mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

### sv/css_back.sv
module css_back
   import css_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     queue_empty,
   input  sums_type queue_data,
   output logic     pop,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   typedef enum logic [2:0] {IDLE, MUL, SRCH_A, SRCH_B, DONE} state_type;

   state_type           state_ff;
   logic [3:0]          cnt_ff;
   logic [3:0]          k_ff;
   logic [SUM_W-1:0]    mag_ff, na_ff, nb_ff, opx;
   logic                neg_ff, zero_ff;
   logic [HALF_W-1:0]   mx, my;
   logic [PROD_W-1:0]   prod_ff;
   logic [1:0]          shf_ff;
   logic                dst_ff, pv_ff;
   logic [PNORM_W-1:0]  p_ff;
   logic [MAGSQ_W-1:0]  m2_ff;
   logic [PNORM_W+1:0]  sh;
   logic [SRCH_W-1:0]   q2p_ff, qp_ff, cand_ff, rhs;
   logic [Q_W-1:0]      q_ff, qs;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;
   logic signed [SUM_W-1:0] dot_w;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign pop       = (state_ff == IDLE) && !queue_empty;
   assign dot_w     = queue_data.dot;

   always_comb begin
      opx = cnt_ff[2] ? mag_ff : nb_ff;
      mx  = cnt_ff[2] ? (cnt_ff[1] ? HALF_W'(mag_ff[SUM_W-1:HALF_W]) : mag_ff[HALF_W-1:0])
                      : (cnt_ff[1] ? HALF_W'(na_ff[SUM_W-1:HALF_W]) : na_ff[HALF_W-1:0]);
      my  = cnt_ff[0] ? HALF_W'(opx[SUM_W-1:HALF_W]) : opx[HALF_W-1:0];
      case (shf_ff)
         2'd0:    sh = (PNORM_W+2)'(prod_ff);
         2'd1:    sh = (PNORM_W+2)'(prod_ff) << HALF_W;
         2'd2:    sh = (PNORM_W+2)'(prod_ff) << (2 * HALF_W);
         default: sh = '0;
      endcase
      rhs = {{(SRCH_W-MAGSQ_W-FRAC_SH){1'b0}}, m2_ff, {FRAC_SH{1'b0}}};
      qs  = (q_ff > ONE_Q14) ? ONE_Q14 : q_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
         pv_ff        <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         pv_ff <= 1'b0;
         case (state_ff)
            IDLE: begin
               if (!queue_empty) begin
                  na_ff   <= queue_data.norm_a;
                  nb_ff   <= queue_data.norm_b;
                  neg_ff  <= dot_w[SUM_W-1];
                  mag_ff  <= dot_w[SUM_W-1] ? SUM_W'(-dot_w) : SUM_W'(dot_w);
                  zero_ff <= (queue_data.norm_a == '0) || (queue_data.norm_b == '0);
                  cnt_ff  <= 4'd0;
                  p_ff    <= '0;
                  m2_ff   <= '0;
                  q_ff    <= '0;
                  q2p_ff  <= '0;
                  qp_ff   <= '0;
                  k_ff    <= 4'(Q_W - 1);
                  if ((queue_data.norm_a == '0) || (queue_data.norm_b == '0)) begin
                     state_ff <= DONE;
                  end else begin
                     state_ff <= MUL;
                  end
               end
            end
            MUL: begin
               if (pv_ff) begin
                  if (dst_ff) m2_ff <= m2_ff + MAGSQ_W'(sh);
                  else p_ff <= p_ff + PNORM_W'(sh);
               end
               if (cnt_ff == 4'd8) begin
                  state_ff <= SRCH_A;
               end else begin
                  prod_ff <= mx * my;
                  shf_ff  <= 2'(cnt_ff[1]) + 2'(cnt_ff[0]);
                  dst_ff  <= cnt_ff[2];
                  pv_ff   <= 1'b1;
                  cnt_ff  <= cnt_ff + 4'd1;
               end
            end
            SRCH_A: begin
               cand_ff  <= q2p_ff + (qp_ff << (5'(k_ff) + 5'd1))
                           + (SRCH_W'(p_ff) << {k_ff, 1'b0});
               state_ff <= SRCH_B;
            end
            SRCH_B: begin
               if (cand_ff <= rhs) begin
                  q2p_ff     <= cand_ff;
                  qp_ff      <= qp_ff + (SRCH_W'(p_ff) << k_ff);
                  q_ff[k_ff] <= 1'b1;
               end
               if (k_ff == 4'd0) begin
                  state_ff <= DONE;
               end else begin
                  k_ff     <= k_ff - 4'd1;
                  state_ff <= SRCH_A;
               end
            end
            DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_ff.zero_norm   <= zero_ff;
                  rsp_ff.similarity  <= zero_ff ? '0
                                        : (neg_ff ? -ELEM_W'(qs) : ELEM_W'(qs));
                  state_ff           <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

endmodule

### tb/tb_cosine_similarity_stream.sv
module tb_cosine_similarity_stream;
   import css_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Settling pause at the end, after every expected result has come back.
   localparam int DRAIN_CYCLES = 200;
   localparam longint CYCLE_LIMIT = 2000000;

   localparam longint DOT_HI  = 64'sd4398046511103;
   localparam longint DOT_LO  = -64'sd4398046511104;
   localparam longint NORM_HI = 64'sd8796093022207;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp;

   cosine_similarity_stream dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   // Running sums held by the predictor, mirroring the block's accumulators.
   longint dot_acc;
   longint norm_a_acc;
   longint norm_b_acc;

   rsp_type expected_sims[$];
   int      error_count;
   longint  cycle_count;
   bit      hold_off;        // set by a test to ask for a long receiver stall
   bit      quiet_receiver;  // no random stalling on the result side

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Cycle counter guarding against a hung block.
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   task automatic report_mismatch(input string what);
      $display("Mismatch at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   // Largest q in [0, 16384] with q * sqrt(na * nb) <= mag * 2^14, found by
   // squaring both sides: q^2 * na * nb <= mag^2 * 2^28. The operands run to
   // about 114 bits, so wide unsigned vectors keep the comparison exact.
   function automatic logic [14:0] cosine_quotient(input longint mag, input longint na,
                                                   input longint nb);
      logic [191:0] rhs;
      logic [191:0] lhs;
      int           lo;
      int           hi;
      int           mid;
      lo  = 0;
      hi  = 16384;
      rhs = (192'(mag) * 192'(mag)) << 28;
      while (lo < hi) begin
         mid = lo + (hi - lo + 1) / 2;
         lhs = 192'(mid) * 192'(mid) * 192'(na) * 192'(nb);
         if (lhs <= rhs) begin
            lo = mid;
         end else begin
            hi = mid - 1;
         end
      end
      return 15'(lo);
   endfunction

   // Folds one accepted element pair into the sums and, on a last pair,
   // queues the similarity the block must produce.
   task automatic accumulate_pair(input req_type beat);
      longint  a;
      longint  b;
      longint  mag;
      longint  q;
      rsp_type sim;
      a = longint'(beat.elem_a);
      b = longint'(beat.elem_b);
      dot_acc = dot_acc + a * b;
      if (dot_acc > DOT_HI) dot_acc = DOT_HI;
      if (dot_acc < DOT_LO) dot_acc = DOT_LO;
      norm_a_acc = norm_a_acc + a * a;
      if (norm_a_acc > NORM_HI) norm_a_acc = NORM_HI;
      norm_b_acc = norm_b_acc + b * b;
      if (norm_b_acc > NORM_HI) norm_b_acc = NORM_HI;
      if (beat.last_elem) begin
         if (norm_a_acc == 0 || norm_b_acc == 0) begin
            sim.similarity = '0;
            sim.zero_norm  = 1'b1;
         end else begin
            mag = (dot_acc < 0) ? -dot_acc : dot_acc;
            q   = longint'(cosine_quotient(mag, norm_a_acc, norm_b_acc));
            sim.similarity = 16'((dot_acc < 0) ? -q : q);
            sim.zero_norm  = 1'b0;
         end
         expected_sims.push_back(sim);
         dot_acc    = 0;
         norm_a_acc = 0;
         norm_b_acc = 0;
      end
   endtask

   // Mostly short gaps, now and then a long one.
   function automatic int random_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Sends one beat: valid rises at a clock edge and the payload is held
   // until the edge at which stall is low. The prediction is updated at
   // that edge, so it is always ahead of the result it covers.
   task automatic send_pair(input logic signed [15:0] a, input logic signed [15:0] b,
                            input logic last, input bit allow_gap);
      int      gap;
      req_type beat;
      beat.elem_a    = a;
      beat.elem_b    = b;
      beat.last_elem = last;
      gap = allow_gap ? random_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req       <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      accumulate_pair(beat);
   endtask

   task automatic end_of_burst();
      req_valid <= 1'b0;
   endtask

   // Result checker: a beat is taken at each edge with valid high and stall low.
   initial begin
      rsp_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (expected_sims.size() == 0) begin
               report_mismatch($sformatf("unexpected result sim=%0d zero=%0b",
                                         rsp.similarity, rsp.zero_norm));
            end else begin
               want = expected_sims.pop_front();
               if (rsp.similarity !== want.similarity)
                  report_mismatch($sformatf("similarity %0d, expected %0d",
                                            rsp.similarity, want.similarity));
               if (rsp.zero_norm !== want.zero_norm)
                  report_mismatch($sformatf("zero_norm %0b, expected %0b",
                                            rsp.zero_norm, want.zero_norm));
            end
         end
      end
   end

   // Receiver stall generator. A long hold-off is counted here in cycles so
   // that the sender keeps offering beats while the block backs up.
   initial begin
      int stall_len;
      int run_len;
      rsp_stall <= 1'b0;
      @(negedge reset);
      forever begin
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (600) @(posedge clock);
            hold_off = 1'b0;
         end else if (quiet_receiver) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            run_len   = $urandom_range(1, 12);
            stall_len = random_gap();
            rsp_stall <= 1'b0;
            repeat (run_len) @(posedge clock);
            if (stall_len > 0) begin
               rsp_stall <= 1'b1;
               repeat (stall_len) @(posedge clock);
            end
         end
      end
   end

   // Random Q1.15 element, with the extremes turning up often.
   function automatic logic signed [15:0] random_elem();
      case ($urandom_range(0, 9))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'sh0000;
         default: return 16'($urandom());
      endcase
   endfunction

   task automatic send_vector_pair(input int len, input bit allow_gap);
      for (int i = 0; i < len; i++)
         send_pair(random_elem(), random_elem(), i == len - 1, allow_gap);
   endtask

   // Directed cases: single extremes, parallel and opposed vectors, zero norms.
   task automatic test_directed();
      send_pair(16'sh7FFF, 16'sh7FFF, 1'b1, 1'b0);          // identical, +1
      send_pair(16'sh8000, 16'sh7FFF, 1'b1, 1'b0);          // opposed, -1
      send_pair(16'sh8000, 16'sh8000, 1'b1, 1'b0);          // both most negative
      send_pair(16'sh0000, 16'sh1234, 1'b1, 1'b0);          // zero norm in a
      send_pair(16'sh4321, 16'sh0000, 1'b1, 1'b0);          // zero norm in b
      send_pair(16'sh0000, 16'sh0000, 1'b1, 1'b0);          // both zero
      send_pair(16'sh0001, 16'shFFFF, 1'b1, 1'b0);          // smallest magnitudes
      // Orthogonal pair of vectors gives exactly zero without the zero flag.
      send_pair(16'sh4000, 16'sh0000, 1'b0, 1'b0);
      send_pair(16'sh0000, 16'sh4000, 1'b1, 1'b0);
      // A partial similarity over a few elements.
      send_pair(16'sh2000, 16'sh1000, 1'b0, 1'b0);
      send_pair(16'shE000, 16'sh3000, 1'b0, 1'b0);
      send_pair(16'sh5555, 16'shAAAA, 1'b0, 1'b1);
      send_pair(16'sh7FFF, 16'sh8001, 1'b1, 1'b1);
      send_pair(16'sh5A5A, 16'shA5A5, 1'b1, 1'b1);
      end_of_burst();
   endtask

   // Long runs of extreme elements push the sums far up their range, so the
   // wide products and the limit at plus and minus one get exercised.
   task automatic test_long_extremes();
      for (int i = 0; i < 300; i++)
         send_pair(16'sh8000, 16'sh8000, i == 299, 1'b0);
      for (int i = 0; i < 300; i++)
         send_pair(16'sh8000, 16'sh7FFF, i == 299, 1'b0);
      end_of_burst();
   endtask

   // Mostly short vectors, now and then a longer one, with random content and random gaps on both sides.
   task automatic test_random_vectors();
      int len;
      for (int n = 0; n < 60; n++) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 6);
         send_vector_pair(len, 1'b1);
      end
      end_of_burst();
   endtask

   // The receiver holds off for a long stretch while single-pair vectors
   // keep coming, so the sums queue fills and the input stalls.
   task automatic test_back_pressure();
      hold_off = 1'b1;
      for (int n = 0; n < 120; n++)
         send_pair(random_elem(), random_elem(), 1'b1, 1'b0);
      end_of_burst();
   endtask

   // Full throughput with no idling on either side.
   task automatic test_no_gaps();
      quiet_receiver = 1'b1;
      for (int n = 0; n < 60; n++)
         send_vector_pair($urandom_range(1, 4), 1'b0);
      end_of_burst();
      wait_for_results();
      quiet_receiver = 1'b0;
   endtask

   task automatic wait_for_results();
      while (expected_sims.size() != 0) @(posedge clock);
   endtask

   initial begin
      error_count    = 0;
      hold_off       = 1'b0;
      quiet_receiver = 1'b0;
      dot_acc        = 0;
      norm_a_acc     = 0;
      norm_b_acc     = 0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req       <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_long_extremes();
      test_random_vectors();
      test_back_pressure();
      test_no_gaps();
      test_random_vectors();

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### files.f
sv/css_pkg.sv
sv/css_front.sv
sv/css_fifo.sv
sv/css_back.sv
sv/cosine_similarity_stream.sv
tb/tb_cosine_similarity_stream.sv
